[hw/rtl/assist_direction_torque_ramp_unit_macros.svh]
// assertion helpers used by the ramp rtl
`ifndef ASSIST_DIRECTION_TORQUE_RAMP_UNIT_MACROS_SVH
`define ASSIST_DIRECTION_TORQUE_RAMP_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ADTR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("adtr assertion failed");

// next-cycle implication, disabled while in reset
`define ADTR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("adtr assertion failed");

`endif

[hw/rtl/adtr_pkg.sv]
package adtr_pkg;

  // ramp length in gain steps
  localparam int GAIN_STEPS = 10;
  localparam int STEP_W     = (GAIN_STEPS > 2) ? $clog2(GAIN_STEPS) : 1;
  localparam logic [STEP_W-1:0] MAX_STEP = STEP_W'(GAIN_STEPS - 1);

  localparam int TABLE_LEN = 10;
  localparam int PCT_W     = 7;

  typedef logic [PCT_W-1:0] pct_tbl_t [TABLE_LEN];
  typedef logic [PCT_W-1:0] gain_tbl_t [GAIN_STEPS];

  // gain in hundredths
  localparam pct_tbl_t GAIN_PCT = '{
    7'd15, 7'd19, 7'd24, 7'd30, 7'd38, 7'd48, 7'd60, 7'd76, 7'd95, 7'd100
  };

  // stretch the table over the configured number of steps
  function automatic gain_tbl_t build_step_gain();
    gain_tbl_t t;
    int        idx;
    for (int i = 0; i < GAIN_STEPS; i++) begin
      idx = (i * (TABLE_LEN - 1)) / (GAIN_STEPS - 1);
      if (idx > TABLE_LEN - 1) begin
        idx = TABLE_LEN - 1;
      end
      t[i] = GAIN_PCT[idx];
    end
    return t;
  endfunction

  localparam gain_tbl_t STEP_GAIN = build_step_gain();

  // |intensity| * gain, at most 32768 * 100
  localparam int PROD_W      = 22;
  // divide by 100: multiply by ceil(2^29 / 100), shift right 29
  localparam int RECIP_W     = 23;
  localparam int RECIP_SHIFT = 29;
  localparam logic [RECIP_W-1:0] RECIP_100 = 23'd5368710;
  localparam int MAG_W       = 16;

  localparam int SPEED_W  = 16;
  localparam int TORQUE_W = 16;

  typedef logic signed [1:0] dir_t;
  localparam dir_t DIR_NONE = 2'sb00;
  localparam dir_t DIR_FWD  = 2'sb01;
  localparam dir_t DIR_REV  = 2'sb11;

  typedef enum logic [2:0] {
    MODE_OFF    = 3'd0,
    MODE_FIXED  = 3'd1,
    MODE_BOTH   = 3'd2,
    MODE_RESIST = 3'd3,
    MODE_FWD    = 3'd4,
    MODE_REV    = 3'd5
  } mode_t;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ASSIST_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTENSITY   = 2'd1;

  localparam logic signed [SPEED_W-1:0] FAST_POS   = 16'sd80;
  localparam logic signed [SPEED_W-1:0] FAST_NEG   = -16'sd80;
  localparam logic signed [SPEED_W-1:0] ASSIST_POS = 16'sd30;
  localparam logic signed [SPEED_W-1:0] ASSIST_NEG = -16'sd30;
  localparam logic signed [SPEED_W-1:0] RESIST_POS = 16'sd10;
  localparam logic signed [SPEED_W-1:0] RESIST_NEG = -16'sd10;
  localparam logic signed [SPEED_W-1:0] FIXED_POS  = 16'sd20;
  localparam logic signed [SPEED_W-1:0] FIXED_NEG  = -16'sd20;
  localparam logic signed [TORQUE_W-1:0] FIXED_TQ_POS = 16'sd10;
  localparam logic signed [TORQUE_W-1:0] FIXED_TQ_NEG = -16'sd10;

  // torque override from the mode rules
  typedef struct packed {
    logic                       force_tq;
    logic signed [TORQUE_W-1:0] value;
  } mode_tq_t;

  // gain step movement decided by the ramp
  typedef struct packed {
    logic up;
    logic down;
  } step_mv_t;

  // scaled magnitude handed to the ramp
  typedef struct packed {
    logic [MAG_W-1:0] mag;
    logic             int_neg;
  } scale_t;

endpackage

[hw/rtl/adtr_dir.sv]
module adtr_dir
  import adtr_pkg::*;
(
  input  logic [2:0]                mode,
  input  logic signed [SPEED_W-1:0] speed,
  input  dir_t                      dir_cur,
  output dir_t                      dir_new,
  output mode_tq_t                  mode_tq
);

  always_comb begin
    dir_new          = dir_cur;
    mode_tq.force_tq = 1'b0;
    mode_tq.value    = '0;
    case (mode_t'(mode))
      MODE_OFF: begin
        dir_new          = DIR_NONE;
        mode_tq.force_tq = 1'b1;
      end
      MODE_FIXED: begin
        mode_tq.force_tq = 1'b1;
        if (speed > FIXED_POS) begin
          mode_tq.value = FIXED_TQ_POS;
        end else if (speed < FIXED_NEG) begin
          mode_tq.value = FIXED_TQ_NEG;
        end
      end
      MODE_BOTH: begin
        if (speed < ASSIST_POS && speed > ASSIST_NEG) begin
          dir_new = DIR_NONE;
        end else if (speed > FAST_POS || (dir_cur == DIR_FWD && speed > ASSIST_POS)) begin
          dir_new = DIR_FWD;
        end else if (speed < FAST_NEG || (dir_cur == DIR_REV && speed < ASSIST_NEG)) begin
          dir_new = DIR_REV;
        end
      end
      MODE_RESIST: begin
        if (speed < RESIST_POS && speed > RESIST_NEG) begin
          dir_new = DIR_NONE;
        end else if (speed > FAST_POS || (dir_cur == DIR_REV && speed > RESIST_POS)) begin
          dir_new = DIR_REV;
        end else if (speed < FAST_NEG || (dir_cur == DIR_FWD && speed < RESIST_NEG)) begin
          dir_new = DIR_FWD;
        end
      end
      MODE_FWD: begin
        if (speed < ASSIST_POS && dir_cur == DIR_FWD) begin
          dir_new = DIR_NONE;
        end else if (speed > FAST_POS || dir_cur == DIR_FWD) begin
          dir_new = DIR_FWD;
        end else begin
          dir_new = DIR_NONE;
        end
      end
      MODE_REV: begin
        if (speed > ASSIST_NEG && dir_cur == DIR_REV) begin
          dir_new = DIR_NONE;
        end else if (speed < FAST_NEG || dir_cur == DIR_REV) begin
          dir_new = DIR_REV;
        end else begin
          dir_new = DIR_NONE;
        end
      end
      default: begin
        dir_new = DIR_NONE;
      end
    endcase
  end

endmodule

[hw/rtl/adtr_scale.sv]
module adtr_scale
  import adtr_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic signed [TORQUE_W-1:0] intensity_nxt,
  input  logic signed [TORQUE_W-1:0] intensity_cur,
  input  logic [STEP_W-1:0]          gain_step,
  input  step_mv_t                   step_mv,
  output scale_t                     scale
);

  localparam int MUL_W = PROD_W + RECIP_W;

  logic [STEP_W-1:0]  step_sel;
  logic [TORQUE_W:0]  int_mag;
  logic [23:0]        prod_full;
  logic [PROD_W-1:0]  prod_nxt;
  logic [PROD_W-1:0]  prod_r;
  logic [MUL_W-1:0]   quot_full;

  // product for the step that will be current after this edge
  always_comb begin
    step_sel = gain_step;
    if (step_mv.up && gain_step != MAX_STEP) begin
      step_sel = gain_step + 1'b1;
    end else if (step_mv.down && gain_step != '0) begin
      step_sel = gain_step - 1'b1;
    end
    int_mag   = intensity_nxt[TORQUE_W-1] ? ((TORQUE_W+1)'(0) - {1'b1, intensity_nxt})
                                          : {1'b0, intensity_nxt};
    prod_full = 24'(int_mag) * 24'(STEP_GAIN[step_sel]);
    prod_nxt  = prod_full[PROD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_r <= '0;
    end else begin
      prod_r <= prod_nxt;
    end
  end

  // truncating divide by 100
  assign quot_full     = MUL_W'(prod_r) * MUL_W'(RECIP_100);
  assign scale.mag     = quot_full[RECIP_SHIFT +: MAG_W];
  assign scale.int_neg = intensity_cur[TORQUE_W-1];

endmodule

[hw/rtl/adtr_ramp.sv]
`include "assist_direction_torque_ramp_unit_macros.svh"

module adtr_ramp
  import adtr_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  dir_t                       dir_new,
  input  mode_tq_t                   mode_tq,
  input  scale_t                     scale,
  output dir_t                       dir_o,
  output logic signed [TORQUE_W-1:0] torque_o,
  output logic [1:0]                 phase_o,
  output logic [STEP_W-1:0]          gain_step_o,
  output step_mv_t                   step_mv
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_ACCEL = 2'd1,
    PH_DECEL = 2'd2
  } phase_t;

  phase_t                     phase_r, phase_nxt, phase_mid;
  dir_t                       dir_r;
  dir_t                       decel_sign_r, decel_sign_nxt;
  logic signed [TORQUE_W-1:0] torque_r, torque_nxt;
  logic [STEP_W-1:0]          gain_step_r, gain_step_nxt;
  logic                       stopped, started;

  // signed, truncated, saturated torque for a given sign
  function automatic logic signed [TORQUE_W-1:0] apply_sign(dir_t sgn, scale_t sc);
    logic neg;
    neg = (sgn == DIR_REV) ^ sc.int_neg;
    if (sgn == DIR_NONE) begin
      return '0;
    end else if (neg) begin
      return TORQUE_W'((TORQUE_W+1)'(0) - {1'b0, sc.mag});
    end else if (sc.mag[MAG_W-1]) begin
      return {1'b0, {(TORQUE_W-1){1'b1}}};
    end else begin
      return $signed(sc.mag);
    end
  endfunction

  always_comb begin
    stopped        = (dir_r != DIR_NONE) && (dir_new == DIR_NONE);
    started        = (dir_r == DIR_NONE) && (dir_new != DIR_NONE);
    phase_mid      = phase_r;
    decel_sign_nxt = decel_sign_r;
    if (stopped) begin
      phase_mid      = PH_DECEL;
      decel_sign_nxt = dir_r;
    end else if (started) begin
      phase_mid = PH_ACCEL;
    end

    torque_nxt    = mode_tq.force_tq ? mode_tq.value : torque_r;
    phase_nxt     = phase_mid;
    gain_step_nxt = gain_step_r;
    step_mv       = '0;
    case (phase_mid)
      PH_ACCEL: begin
        if (dir_new != DIR_NONE) begin
          torque_nxt = apply_sign(dir_new, scale);
          if (gain_step_r < MAX_STEP) begin
            gain_step_nxt = gain_step_r + 1'b1;
            step_mv.up    = en;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      end
      PH_DECEL: begin
        if (dir_new == DIR_NONE) begin
          if (gain_step_r != '0) begin
            torque_nxt    = apply_sign(decel_sign_nxt, scale);
            gain_step_nxt = gain_step_r - 1'b1;
            step_mv.down  = en;
          end else begin
            torque_nxt = '0;
            phase_nxt  = PH_IDLE;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      dir_r        <= DIR_NONE;
      decel_sign_r <= DIR_NONE;
      torque_r     <= '0;
      gain_step_r  <= MAX_STEP;
    end else if (en) begin
      phase_r      <= phase_nxt;
      dir_r        <= dir_new;
      decel_sign_r <= decel_sign_nxt;
      torque_r     <= torque_nxt;
      gain_step_r  <= gain_step_nxt;
    end
  end

  assign dir_o       = dir_r;
  assign torque_o    = torque_r;
  assign phase_o     = phase_r;
  assign gain_step_o = gain_step_r;

  `ADTR_ASSERT_IMP(a_step_in_range, clk, rst_n, 1'b1, gain_step_r <= MAX_STEP)
  `ADTR_ASSERT_NXT(a_hold_when_no_item, clk, rst_n, !en,
                   $stable(torque_r) && $stable(gain_step_r) && $stable(dir_r))
  `ADTR_ASSERT_NXT(a_idle_keeps_step, clk, rst_n,
                   en && phase_r == PH_IDLE && dir_new == dir_r, $stable(gain_step_r))
  `ADTR_ASSERT_NXT(a_decel_end_zero, clk, rst_n,
                   en && phase_r == PH_DECEL && dir_new == DIR_NONE && gain_step_r == '0,
                   torque_r == '0 && phase_r == PH_IDLE)

endmodule

[hw/rtl/assist_direction_torque_ramp_unit.sv]
// assist direction and torque ramp
// input channel: one signed speed sample per beat (in_valid / in_stall).
// result channel: one beat per input beat carrying held torque, direction,
//   ramp phase and gain step (out_valid / out_stall).
// config channel: cfg_valid / cfg_ready write of assist mode (index 0) or
//   intensity (index 1); cfg_ready is always high, writes are expected only
//   while no sample is in flight.
// path: a sample accepted into the input register waits there until the result
//   slot is free, then the state update that also drives the result takes it.
// throughput: one sample per cycle while the result port is not stalled; the limit is
//   the state loop through the mode rules, the divide-by-100 multiply and the ramp update.
// stall: while out_stall holds a result, the sample waiting in the input
//   register backs up and in_stall rises; the result fields stay unchanged.
// reset: synchronous on rst_n low; direction and torque clear, the ramp goes
//   idle with the gain at its top step, mode off and intensity zero.
module assist_direction_torque_ramp_unit
  import adtr_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [SPEED_W-1:0]   in_speed_sample,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [TORQUE_W-1:0]  out_torque_command,
  output logic signed [1:0]           out_direction_out,
  output logic [1:0]                  out_ramp_phase_out,
  output logic [3:0]                  out_gain_step_out,
  // configuration write channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [15:0]                 cfg_wdata
);

  // configuration registers
  logic [2:0]                 mode_r, mode_nxt;
  logic signed [TORQUE_W-1:0] intensity_r, intensity_nxt;

  // input register and result valid
  logic                       in_v_r, in_v_nxt;
  logic signed [SPEED_W-1:0]  speed_r;
  logic                       out_v_r, out_v_nxt;

  logic       in_take;
  logic       advance;
  logic       cfg_take;

  dir_t                       dir_cur;
  dir_t                       dir_new;
  mode_tq_t                   mode_tq;
  scale_t                     scale;
  step_mv_t                   step_mv;
  logic signed [TORQUE_W-1:0] torque;
  logic [1:0]                 phase;
  logic [STEP_W-1:0]          gain_step;

  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid && cfg_ready;

  always_comb begin
    mode_nxt      = mode_r;
    intensity_nxt = intensity_r;
    if (cfg_take) begin
      case (cfg_index)
        REG_ASSIST_MODE: mode_nxt      = cfg_wdata[2:0];
        REG_INTENSITY:   intensity_nxt = $signed(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  // the held sample moves into the state when the result slot is free
  assign advance  = in_v_r && (!out_v_r || !out_stall);
  assign in_stall = in_v_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_take) begin
      in_v_nxt = 1'b1;
    end else if (advance) begin
      in_v_nxt = 1'b0;
    end
    out_v_nxt = advance || (out_v_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_OFF;
      intensity_r <= '0;
      in_v_r      <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      intensity_r <= intensity_nxt;
      in_v_r      <= in_v_nxt;
      out_v_r     <= out_v_nxt;
    end
  end

  // sample payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_take) begin
      speed_r <= in_speed_sample;
    end
  end

  adtr_dir u_dir (
    .mode    (mode_r),
    .speed   (speed_r),
    .dir_cur (dir_cur),
    .dir_new (dir_new),
    .mode_tq (mode_tq)
  );

  // product for the current step is kept registered
  adtr_scale u_scale (
    .clk           (clk),
    .rst_n         (rst_n),
    .intensity_nxt (intensity_nxt),
    .intensity_cur (intensity_r),
    .gain_step     (gain_step),
    .step_mv       (step_mv),
    .scale         (scale)
  );

  // the ramp state registers double as the result register
  adtr_ramp u_ramp (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (advance),
    .dir_new     (dir_new),
    .mode_tq     (mode_tq),
    .scale       (scale),
    .dir_o       (dir_cur),
    .torque_o    (torque),
    .phase_o     (phase),
    .gain_step_o (gain_step),
    .step_mv     (step_mv)
  );

  assign out_valid          = out_v_r;
  assign out_torque_command = torque;
  assign out_direction_out  = dir_cur;
  assign out_ramp_phase_out = phase;
  assign out_gain_step_out  = 4'(gain_step);

endmodule
